### src/assert_macros.svh
// Assertion helpers for the ALU block.
// Both macros check on the rising clock edge and are disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SFBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define SFBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SFBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SFBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### src/sfba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfba_pkg: shared types and constants for the 64-bit ALU
// Operation codes, the datapath width and the per-cell pipeline payload.
// ---------------------------------------------------------------------------
package sfba_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int ACT_W      = 5;
  localparam int SHAMT_W    = $clog2(DATA_WIDTH);
  localparam int NUM_CELLS  = DATA_WIDTH;

  // Operation codes
  localparam logic [ACT_W-1:0] OP_ADD  = 5'd0;
  localparam logic [ACT_W-1:0] OP_SUB  = 5'd1;
  localparam logic [ACT_W-1:0] OP_MUL  = 5'd2;
  localparam logic [ACT_W-1:0] OP_DIV  = 5'd3;
  localparam logic [ACT_W-1:0] OP_MOD  = 5'd4;
  localparam logic [ACT_W-1:0] OP_XOR  = 5'd5;
  localparam logic [ACT_W-1:0] OP_OR   = 5'd6;
  localparam logic [ACT_W-1:0] OP_AND  = 5'd7;
  localparam logic [ACT_W-1:0] OP_SHL  = 5'd8;
  localparam logic [ACT_W-1:0] OP_SHR  = 5'd9;
  localparam logic [ACT_W-1:0] OP_LT   = 5'd10;
  localparam logic [ACT_W-1:0] OP_GT   = 5'd11;
  localparam logic [ACT_W-1:0] OP_NE   = 5'd12;
  localparam logic [ACT_W-1:0] OP_ANDNZ = 5'd13;
  localparam logic [ACT_W-1:0] OP_ABMA = 5'd14;
  localparam logic [ACT_W-1:0] OP_ANDN = 5'd15;
  localparam logic [ACT_W-1:0] OP_SADD = 5'd16;
  localparam logic [ACT_W-1:0] OP_SSUB = 5'd17;
  localparam logic [ACT_W-1:0] OP_SMUL = 5'd18;
  localparam logic [ACT_W-1:0] OP_SDIV = 5'd19;
  localparam logic [ACT_W-1:0] OP_SMOD = 5'd20;
  localparam logic [ACT_W-1:0] OP_SLT  = 5'd21;
  localparam logic [ACT_W-1:0] OP_SGT  = 5'd22;
  localparam logic [ACT_W-1:0] OP_INC  = 5'd23;
  localparam logic [ACT_W-1:0] OP_DEC  = 5'd24;
  localparam logic [ACT_W-1:0] OP_NOT  = 5'd25;
  localparam logic [ACT_W-1:0] OP_NZ   = 5'd26;

  // Payload carried from cell to cell
  typedef struct packed {
    logic [ACT_W-1:0]      act;
    logic [DATA_WIDTH-1:0] res;    // result of the ops worked out in the prep stage
    logic [DATA_WIDTH-1:0] prod;   // multiply accumulator
    logic [DATA_WIDTH-1:0] mcand;  // shifted multiplicand
    logic [DATA_WIDTH-1:0] mplier; // multiplier, consumed LSB first
    logic [DATA_WIDTH-1:0] quo;    // dividend bits out, quotient bits in
    logic [DATA_WIDTH-1:0] rem;    // partial remainder
    logic [DATA_WIDTH-1:0] dvs;    // divisor magnitude
    logic                  neg_q;  // negate quotient at the end
    logic                  neg_r;  // negate remainder at the end
    logic                  dz;     // divisor is zero
  } sfba_cell_t;

endpackage

### src/sfba_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfba_prep: operand preparation stage
// Works out the results of all other ops and loads the multiply/divide cells.
// ---------------------------------------------------------------------------
module sfba_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [sfba_pkg::ACT_W-1:0] act,
  input  logic [63:0]                opa,
  input  logic [63:0]                opb,
  output logic                       vld_o,
  output sfba_pkg::sfba_cell_t       dat_o
);
  import sfba_pkg::*;

  logic                  vld_r;
  sfba_cell_t            dat_r;
  sfba_cell_t            dat_nxt;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  sgn;
  logic                  a_neg;
  logic                  b_neg;
  logic                  shift_big;
  logic                  s_lt;

  assign a         = opa[DATA_WIDTH-1:0];
  assign b         = opb[DATA_WIDTH-1:0];
  assign a_neg     = a[DATA_WIDTH-1];
  assign b_neg     = b[DATA_WIDTH-1];
  assign sgn       = (act == OP_SDIV) || (act == OP_SMOD);
  assign shift_big = (b >= DATA_WIDTH);
  assign s_lt      = (a_neg != b_neg) ? a_neg : (a < b);

  // Prep-stage ops and cell loading
  always_comb begin
    dat_nxt        = '0;
    dat_nxt.act    = act;
    dat_nxt.mcand  = a;
    dat_nxt.mplier = b;
    dat_nxt.quo    = (sgn && a_neg) ? (~a + 1'b1) : a;
    dat_nxt.dvs    = (sgn && b_neg) ? (~b + 1'b1) : b;
    dat_nxt.neg_q  = sgn && (a_neg != b_neg);
    dat_nxt.neg_r  = sgn && a_neg;
    dat_nxt.dz     = (b == '0);
    case (act)
      OP_ADD, OP_SADD: dat_nxt.res = a + b;
      OP_SUB, OP_SSUB: dat_nxt.res = a - b;
      OP_XOR:   dat_nxt.res = a ^ b;
      OP_OR:    dat_nxt.res = a | b;
      OP_AND:   dat_nxt.res = a & b;
      OP_SHL:   dat_nxt.res = shift_big ? '0 : (a << b[SHAMT_W-1:0]);
      OP_SHR:   dat_nxt.res = shift_big ? '0 : (a >> b[SHAMT_W-1:0]);
      OP_LT:    dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, (a < b)};
      OP_GT:    dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, (a > b)};
      OP_NE:    dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, (a != b)};
      OP_ANDNZ: dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, ((a & b) != '0)};
      OP_ABMA:  dat_nxt.res = a & (b - a);
      OP_ANDN:  dat_nxt.res = a & ~b;
      OP_SLT:   dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, s_lt};
      OP_SGT:   dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, ((a != b) && !s_lt)};
      OP_INC:   dat_nxt.res = a + 1'b1;
      OP_DEC:   dat_nxt.res = a - 1'b1;
      OP_NOT:   dat_nxt.res = ~a;
      OP_NZ:    dat_nxt.res = {{(DATA_WIDTH-1){1'b0}}, (a != '0)};
      default:  dat_nxt.res = '0;
    endcase
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

### src/sfba_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfba_cell: one step of the multiply/divide chain
// One shift-add multiply step and one restoring divide step per cell.
// ---------------------------------------------------------------------------
module sfba_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_i,
  input  sfba_pkg::sfba_cell_t dat_i,
  output logic                 vld_o,
  output sfba_pkg::sfba_cell_t dat_o
);
  import sfba_pkg::*;

  logic                vld_r;
  sfba_cell_t          dat_r;
  sfba_cell_t          dat_nxt;
  logic [DATA_WIDTH:0] sh;
  logic [DATA_WIDTH:0] trial;
  logic                ge;

  // Divide: shift in next dividend bit, subtract if it fits
  assign sh    = {dat_i.rem, dat_i.quo[DATA_WIDTH-1]};
  assign trial = sh - {1'b0, dat_i.dvs};
  assign ge    = !trial[DATA_WIDTH];

  always_comb begin
    dat_nxt        = dat_i;
    dat_nxt.rem    = ge ? trial[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
    dat_nxt.quo    = {dat_i.quo[DATA_WIDTH-2:0], ge};
    // Multiply: accumulate the multiplicand when the multiplier bit is set
    dat_nxt.prod   = dat_i.prod + (dat_i.mplier[0] ? dat_i.mcand : '0);
    dat_nxt.mcand  = {dat_i.mcand[DATA_WIDTH-2:0], 1'b0};
    dat_nxt.mplier = {1'b0, dat_i.mplier[DATA_WIDTH-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

### src/sixty_four_bit_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sixty_four_bit_alu: pipelined 64-bit integer ALU
// Prep stage, a chain of 64 multiply/divide cells and an output register.
// ---------------------------------------------------------------------------
// Usage:
//   Input transaction: in_action, in_operand_a, in_operand_b, taken when
//   in_valid is high and in_stall is low. Output transaction: out_result,
//   delivered when out_valid is high and out_stall is low.
//   Every operation takes the same path: one prep stage, 64 cells (one
//   quotient bit and one multiplier bit per cell) and the output register,
//   so results leave in issue order.
//   Throughput is one transaction per cycle unless a waiting result is stalled;
//   the whole pipeline advances together, and its depth sets the latency.
//   When the receiver stalls with a result waiting, the entire pipeline
//   holds and in_stall is raised until the result is taken.
//   Reset clears all valid flags; the pipeline comes up empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sixty_four_bit_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_action,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result
);
  import sfba_pkg::*;

  logic                  adv;
  logic                  vld_w [0:NUM_CELLS];
  sfba_cell_t            dat_w [0:NUM_CELLS];
  sfba_cell_t            last;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_result_r;
  logic [DATA_WIDTH-1:0] fin;
  logic                  last_dz_div;
  logic                  last_cmp;

  // Pipeline moves when the output register is free or being emptied
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  sfba_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .act    (in_action),
    .opa    (in_operand_a),
    .opb    (in_operand_b),
    .vld_o  (vld_w[0]),
    .dat_o  (dat_w[0])
  );

  // Multiply/divide cell chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sfba_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld_w[i]),
      .dat_i (dat_w[i]),
      .vld_o (vld_w[i+1]),
      .dat_o (dat_w[i+1])
    );
  end

  assign last = dat_w[NUM_CELLS];

  // Final selection and sign fix-up
  always_comb begin
    case (last.act)
      OP_MUL, OP_SMUL: fin = last.prod;
      OP_DIV, OP_SDIV: fin = last.dz ? '0 : (last.neg_q ? (~last.quo + 1'b1) : last.quo);
      OP_MOD, OP_SMOD: fin = last.dz ? '0 : (last.neg_r ? (~last.rem + 1'b1) : last.rem);
      default:         fin = last.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_w[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= fin;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = {{(64-DATA_WIDTH){1'b0}}, out_result_r};

  // Checks
  assign last_dz_div = last.dz && (last.act == OP_DIV || last.act == OP_MOD ||
                                   last.act == OP_SDIV || last.act == OP_SMOD);
  assign last_cmp    = last.act == OP_LT || last.act == OP_GT || last.act == OP_NE ||
                       last.act == OP_ANDNZ || last.act == OP_SLT ||
                       last.act == OP_SGT || last.act == OP_NZ;

  `SFBA_ASSERT_NXT(a_div_zero, clk, rst_n, adv && vld_w[NUM_CELLS] && last_dz_div, out_result == 64'd0, "division by zero did not give zero")
  `SFBA_ASSERT_NXT(a_cmp_bool, clk, rst_n, adv && vld_w[NUM_CELLS] && last_cmp, out_result[63:1] == 63'd0, "comparison result not 0 or 1")
  `SFBA_ASSERT_IMP(a_hold, clk, rst_n, !adv, out_valid_r, "pipeline held with no result waiting")

endmodule

### sim/sixty_four_bit_alu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sixty_four_bit_alu_checker: result predictor and scoreboard
// Watches both channels, computes the expected result of every accepted
// operation and compares each delivered result with the oldest prediction.
// ---------------------------------------------------------------------------
module sixty_four_bit_alu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_action,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result,
  input  logic        final_check,
  output int          fail_count,
  output int          pending_results
);
  import sfba_pkg::*;

  logic [63:0] result_queue [$];

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] abs_val(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // Expected ALU result for one operation
  function automatic logic [63:0] alu_result(input logic [4:0] op,
                                             input logic [63:0] a,
                                             input logic [63:0] b);
    logic [63:0] q;
    case (op)
      OP_ADD, OP_SADD: return a + b;
      OP_SUB, OP_SSUB: return a - b;
      OP_MUL, OP_SMUL: return a * b;
      OP_DIV:   return (b != 0) ? a / b : 64'd0;
      OP_MOD:   return (b != 0) ? a % b : 64'd0;
      OP_XOR:   return a ^ b;
      OP_OR:    return a | b;
      OP_AND:   return a & b;
      OP_SHL:   return (b >= 64) ? 64'd0 : (a << b[5:0]);
      OP_SHR:   return (b >= 64) ? 64'd0 : (a >> b[5:0]);
      OP_LT:    return {63'd0, a < b};
      OP_GT:    return {63'd0, a > b};
      OP_NE:    return {63'd0, a != b};
      OP_ANDNZ: return {63'd0, (a & b) != 0};
      OP_ABMA:  return a & (b - a);
      OP_ANDN:  return a & ~b;
      OP_SDIV: begin
        if (b == 0) return 64'd0;
        q = abs_val(a) / abs_val(b);
        return (a[63] != b[63]) ? (64'd0 - q) : q;
      end
      OP_SMOD: begin
        if (b == 0) return 64'd0;
        q = abs_val(a) % abs_val(b);
        return a[63] ? (64'd0 - q) : q;
      end
      OP_SLT:   return {63'd0, (a ^ SIGN_BIT) < (b ^ SIGN_BIT)};
      OP_SGT:   return {63'd0, (b ^ SIGN_BIT) < (a ^ SIGN_BIT)};
      OP_INC:   return a + 1;
      OP_DEC:   return a - 1;
      OP_NOT:   return ~a;
      OP_NZ:    return {63'd0, a != 0};
      default:  return 64'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    logic [63:0] expected;
    if (rst_n) begin
      if (in_valid && !in_stall)
        result_queue.push_back(alu_result(in_action, in_operand_a, in_operand_b));
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_result));
        end else begin
          expected = result_queue.pop_front();
          if (out_result !== expected)
            report_mismatch($sformatf("result %h, expected %h", out_result, expected));
        end
      end
    end
    pending_results = result_queue.size();
  end

  // Leftover predictions at the end of the run
  always @(posedge final_check) begin
    if (result_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", result_queue.size()));
  end

endmodule

### sim/sixty_four_bit_alu_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sixty_four_bit_alu_test: top-level testbench for the pipelined ALU
// Drives directed corner operations then random ones with random idling and
// back-pressure; the checker predicts and scores every result.
// ---------------------------------------------------------------------------
module sixty_four_bit_alu_test;
  import sfba_pkg::*;

  localparam int RANDOM_OPS  = 1030;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 100;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_action = OP_ADD;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result;
  logic        final_check = 1'b0;
  int          fail_count;
  int          pending_results;

  bit          hold_req = 1'b0;   // ask for the long receiver hold-off
  bit          hold_off = 1'b0;   // long receiver hold-off in progress
  bit          calm_phase = 1'b0; // stretch with no idling
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  sixty_four_bit_alu dut (.*);

  sixty_four_bit_alu_checker checker_i (.*);

  // Receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm_phase) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 15);
  end

  // Long receiver hold-off, timed in cycles
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one transaction and wait for acceptance
  task automatic send_op(input logic [4:0] op, input logic [63:0] a,
                         input logic [63:0] b);
    while (!calm_phase && !hold_off && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0: w = 64'd0;
      1: w = 64'hFFFF_FFFF_FFFF_FFFF;
      2: w = 64'h8000_0000_0000_0000;
      3: w = $urandom_range(70);
      4: w = w >> $urandom_range(63);
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [4:0] op;
    logic [63:0] a;
    logic [63:0] b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_op(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    send_op(OP_SUB, 64'd0, 64'd1);
    send_op(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_DIV, 64'd1234, 64'd0);
    send_op(OP_MOD, 64'd1234, 64'd0);
    send_op(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7);
    send_op(OP_SDIV, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_SMOD, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_SDIV, -64'sd7, 64'sd2);
    send_op(OP_SMOD, -64'sd7, 64'sd2);
    send_op(OP_SMOD, 64'sd7, -64'sd2);
    send_op(OP_SDIV, 64'sd5, 64'd0);
    send_op(OP_SMOD, -64'sd5, 64'd0);
    send_op(OP_SHL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd63);
    send_op(OP_SHL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd64);
    send_op(OP_SHR, 64'hFFFF_FFFF_FFFF_FFFF, 64'd63);
    send_op(OP_SHR, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_op(OP_SLT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(OP_SGT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(OP_INC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_op(OP_DEC, 64'd0, 64'd0);
    send_op(OP_NZ, 64'd0, 64'd5);
    send_op(5'd27, 64'd3, 64'd4);
    send_op(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    // Pause the sender until the pipeline has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);

    // Random operations with phases of pressure
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 400) calm_phase = 1'b1;
      if (i == 600) calm_phase = 1'b0;
      op = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(26));
      a = rand_word();
      b = rand_word();
      send_op(op, a, b);
    end
    in_valid <= 1'b0;

    // Drain
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    final_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
